### hw/rtl/upc_pkg.sv
// ----------------------------------------------------------------------------
// upc_pkg
// Shared types, character codes and lookup helpers for the URL percent codec.
// ----------------------------------------------------------------------------
package upc_pkg;

  localparam logic [7:0] CH_PCT   = 8'h25;  // '%'
  localparam logic [7:0] CH_PLUS  = 8'h2B;  // '+'
  localparam logic [7:0] CH_SPACE = 8'h20;  // ' '
  localparam logic [7:0] CH_TILDE = 8'h7E;  // '~'
  localparam logic [7:0] CH_DASH  = 8'h2D;  // '-'
  localparam logic [7:0] CH_UNDER = 8'h5F;  // '_'
  localparam logic [7:0] CH_DOT   = 8'h2E;  // '.'

  localparam logic [7:0] HEX_CHARS [16] = '{
    8'h30, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37,
    8'h38, 8'h39, 8'h41, 8'h42, 8'h43, 8'h44, 8'h45, 8'h46
  };

  // What the back end has to emit for one request.
  typedef enum logic [1:0] {
    CMD_ONE      = 2'd0,  // data alone
    CMD_PCT_BYTE = 2'd1,  // '%' then data
    CMD_PCT_HEX  = 2'd2   // '%' then two upper-case hex digits of data
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t  kind;
    logic [7:0] data;
    logic       last;
  } cmd_t;

  // {is_hex, value}
  function automatic logic [4:0] hex_value(input logic [7:0] b);
    logic [4:0] r;
    r = 5'd0;
    if (b >= 8'h30 && b <= 8'h39) begin
      r = {1'b1, 4'(b - 8'h30)};
    end else if (b >= 8'h41 && b <= 8'h46) begin
      r = {1'b1, 4'(b - 8'h37)};
    end else if (b >= 8'h61 && b <= 8'h66) begin
      r = {1'b1, 4'(b - 8'h57)};
    end
    return r;
  endfunction

  function automatic logic passes_unchanged(input logic [7:0] b);
    return (b >= 8'h30 && b <= 8'h39) || (b >= 8'h41 && b <= 8'h5A) ||
           (b >= 8'h61 && b <= 8'h7A) || b == CH_DASH || b == CH_UNDER ||
           b == CH_DOT || b == CH_TILDE;
  endfunction

  function automatic logic [7:0] plain_decode(input logic [7:0] b);
    return (b == CH_PLUS) ? CH_SPACE : b;
  endfunction

endpackage

### hw/rtl/upc_if.sv
// ----------------------------------------------------------------------------
// upc channel interfaces
// Valid/ready channels for string bytes in, converted bytes out, and config.
// ----------------------------------------------------------------------------
interface upc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       in_last;
  modport source (output valid, output in_byte, output in_last, input ready);
  modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

interface upc_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       out_last;
  modport source (output valid, output out_byte, output out_last, input ready);
  modport sink   (input valid, input out_byte, input out_last, output ready);
endinterface

interface upc_cfg_if;
  logic valid;
  logic ready;
  logic direction;
  modport source (output valid, output direction, input ready);
  modport sink   (input valid, input direction, output ready);
endinterface

### hw/rtl/url_percent_codec_top.sv
// An accepted byte goes through the command queue into the back end's cur register.
// Throughput: one input byte per cycle while each yields one output byte and the
//   output is ready; an encoded escape is three bytes on the one-byte output port.
// A queue of QUEUE_DEPTH commands lets input and output stall independently.
// Reset (synchronous, rst high): direction = encode, no escape pending, queue empty.
// ----------------------------------------------------------------------------
// url_percent_codec_top
// Streaming URL percent encoder / decoder (form-urlencoded style).
// ----------------------------------------------------------------------------
module url_percent_codec_top #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic      clk,
  input  logic      rst,
  upc_in_if.sink    item,
  upc_cfg_if.sink   cfg,
  upc_out_if.source result
);
  import upc_pkg::*;

  logic push, pop, full, empty;
  cmd_t push_cmd, head;

  upc_front u_front (
    .clk      (clk),
    .rst      (rst),
    .item     (item),
    .cfg      (cfg),
    .full     (full),
    .push     (push),
    .push_cmd (push_cmd)
  );

  upc_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .head     (head),
    .full     (full),
    .empty    (empty)
  );

  upc_back u_back (
    .clk    (clk),
    .rst    (rst),
    .head   (head),
    .empty  (empty),
    .pop    (pop),
    .result (result)
  );

endmodule

### hw/rtl/upc_front.sv
// ----------------------------------------------------------------------------
// upc_front
// Accepts string bytes, tracks the decode escape state and turns each byte
// into at most one emit command for the back end.
// ----------------------------------------------------------------------------
module upc_front (
  input  logic          clk,
  input  logic          rst,
  upc_in_if.sink        item,
  upc_cfg_if.sink       cfg,
  input  logic          full,
  output logic          push,
  output upc_pkg::cmd_t push_cmd
);
  import upc_pkg::*;

  typedef enum logic [2:0] {
    ESC_NONE = 3'b001,
    ESC_PCT  = 3'b010,
    ESC_HELD = 3'b100
  } esc_state_t;

  logic       direction;
  esc_state_t phase, phase_next;
  logic [7:0] held, held_next;
  logic       accept;
  logic [4:0] hv_hi, hv_lo;
  logic [7:0] pair_value;

  assign item.ready = !full;
  assign cfg.ready  = 1'b1;
  assign accept     = item.valid && item.ready;

  assign hv_hi = hex_value(held);
  assign hv_lo = hex_value(item.in_byte);

  always_comb begin
    if (!hv_hi[4]) begin
      pair_value = 8'd0;
    end else if (!hv_lo[4]) begin
      pair_value = {4'd0, hv_hi[3:0]};
    end else begin
      pair_value = {hv_hi[3:0], hv_lo[3:0]};
    end
  end

  always_comb begin
    push       = 1'b0;
    push_cmd   = '{kind: CMD_ONE, data: item.in_byte, last: item.in_last};
    phase_next = phase;
    held_next  = held;
    if (accept) begin
      if (!direction) begin
        push       = 1'b1;
        phase_next = ESC_NONE;
        if (passes_unchanged(item.in_byte)) begin
          push_cmd.kind = CMD_ONE;
        end else if (item.in_byte == CH_SPACE) begin
          push_cmd.data = CH_PLUS;
        end else begin
          push_cmd.kind = CMD_PCT_HEX;
        end
      end else begin
        unique case (phase)
          ESC_PCT: begin
            if (item.in_last) begin
              // truncated escape: literal '%' then the final byte
              push          = 1'b1;
              push_cmd.kind = CMD_PCT_BYTE;
              push_cmd.data = plain_decode(item.in_byte);
              phase_next    = ESC_NONE;
            end else begin
              held_next  = item.in_byte;
              phase_next = ESC_HELD;
            end
          end
          ESC_HELD: begin
            push          = 1'b1;
            push_cmd.data = pair_value;
            phase_next    = ESC_NONE;
          end
          ESC_NONE: begin
            if (item.in_byte == CH_PCT && !item.in_last) begin
              phase_next = ESC_PCT;
            end else begin
              push          = 1'b1;
              push_cmd.data = plain_decode(item.in_byte);
            end
          end
          default: begin
            phase_next = ESC_NONE;
            push       = 1'b1;
            push_cmd.data = plain_decode(item.in_byte);
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      direction <= 1'b0;
      phase     <= ESC_NONE;
    end else if (cfg.valid && cfg.ready) begin
      direction <= cfg.direction;
      phase     <= ESC_NONE;
    end else begin
      phase <= phase_next;
    end
  end

  always_ff @(posedge clk) begin
    held <= held_next;
  end

  // an escape can only be pending in decode mode
  a_esc_decode_only: assert property (@(posedge clk) disable iff (rst)
    (phase != ESC_NONE) |-> direction)
    else $error("escape pending while encoding");

endmodule

### hw/rtl/upc_queue.sv
// ----------------------------------------------------------------------------
// upc_queue
// Small command FIFO between the front end and the back end.
// ----------------------------------------------------------------------------
module upc_queue #(
  parameter int DEPTH = 4
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  upc_pkg::cmd_t push_cmd,
  input  logic          pop,
  output upc_pkg::cmd_t head,
  output logic          full,
  output logic          empty
);
  import upc_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  cmd_t          mem [DEPTH];
  logic [AW-1:0] wr_ptr, rd_ptr;
  logic [CW-1:0] count;

  assign full  = (count == CW'(DEPTH));
  assign empty = (count == '0);
  assign head  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> !full)
    else $error("push into full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> !empty)
    else $error("pop from empty queue");

endmodule

### hw/rtl/upc_back.sv
// ----------------------------------------------------------------------------
// upc_back
// Takes emit commands from the queue and drives one output byte per cycle
// while the output is ready, stepping through the '%' and following bytes of an escape.
// ----------------------------------------------------------------------------
module upc_back (
  input  logic          clk,
  input  logic          rst,
  input  upc_pkg::cmd_t head,
  input  logic          empty,
  output logic          pop,
  upc_out_if.source     result
);
  import upc_pkg::*;

  logic       cur_valid;
  cmd_t       cur;
  logic [1:0] step;
  logic       final_step;
  logic       fire;
  logic       done;

  always_comb begin
    final_step = 1'b1;
    result.out_byte = cur.data;
    unique case (cur.kind)
      CMD_ONE: begin
        final_step      = 1'b1;
        result.out_byte = cur.data;
      end
      CMD_PCT_BYTE: begin
        final_step      = (step == 2'd1);
        result.out_byte = (step == 2'd0) ? CH_PCT : cur.data;
      end
      CMD_PCT_HEX: begin
        final_step = (step == 2'd2);
        if (step == 2'd0) begin
          result.out_byte = CH_PCT;
        end else if (step == 2'd1) begin
          result.out_byte = HEX_CHARS[cur.data[7:4]];
        end else begin
          result.out_byte = HEX_CHARS[cur.data[3:0]];
        end
      end
      default: begin
        final_step      = 1'b1;
        result.out_byte = cur.data;
      end
    endcase
  end

  assign result.valid    = cur_valid;
  assign result.out_last = cur.last && final_step;
  assign fire            = result.valid && result.ready;
  assign done            = fire && final_step;
  assign pop             = !empty && (!cur_valid || done);

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      step      <= 2'd0;
    end else if (pop) begin
      cur_valid <= 1'b1;
      step      <= 2'd0;
    end else if (done) begin
      cur_valid <= 1'b0;
      step      <= 2'd0;
    end else if (fire) begin
      step <= step + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur <= head;
    end
  end

  // step never runs past the length of the command
  a_step_bound: assert property (@(posedge clk) disable iff (rst)
    cur_valid |-> (step == 2'd0 || (step == 2'd1 && cur.kind != CMD_ONE) ||
                   (step == 2'd2 && cur.kind == CMD_PCT_HEX)))
    else $error("emit step out of range");

endmodule

### verif/url_percent_codec_checker.sv
// ----------------------------------------------------------------------------
// url_percent_codec_checker
// Watches the request, config and output channels of the URL percent codec,
// predicts every output byte from the accepted requests and compares them in
// order. Reports the number of failures and the bytes still outstanding.
// ----------------------------------------------------------------------------
module url_percent_codec_checker
  import upc_pkg::*;
(
  input  logic clk,
  input  logic rst,
  upc_in_if    item,
  upc_cfg_if   cfg,
  upc_out_if   result,
  output int   fail_count,
  output int   pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int REPORT_LIMIT = 10;

  typedef enum logic [1:0] {
    ESC_NONE,
    ESC_PCT_SEEN,
    ESC_DIGIT_HELD
  } esc_phase_t;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } out_char_t;

  out_char_t  expected_chars[$];
  logic       decoding;
  esc_phase_t esc_phase;
  logic [7:0] held_char;

  // -1 when the character is not a hex digit
  function automatic int nibble_of(input logic [7:0] c);
    if (c >= 8'h30 && c <= 8'h39) return int'(c) - 'h30;
    if (c >= 8'h41 && c <= 8'h46) return int'(c) - 'h37;
    if (c >= 8'h61 && c <= 8'h66) return int'(c) - 'h57;
    return -1;
  endfunction

  function automatic logic [7:0] upper_hex(input logic [3:0] n);
    return (n < 4'd10) ? 8'h30 + 8'(n) : 8'h37 + 8'(n);
  endfunction

  function automatic logic is_unreserved(input logic [7:0] c);
    return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h5A) ||
           (c >= 8'h61 && c <= 8'h7A) ||
           c inside {CH_DASH, CH_UNDER, CH_DOT, CH_TILDE};
  endfunction

  function automatic logic [7:0] plus_to_space(input logic [7:0] c);
    return (c == CH_PLUS) ? CH_SPACE : c;
  endfunction

  task automatic expect_char(input logic [7:0] data, input logic last);
    expected_chars.push_back('{data: data, last: last});
  endtask

  task automatic log_failure(input string msg);
    if (fail_count < REPORT_LIMIT) $display("%0t ns: %s", $realtime, msg);
    fail_count++;
  endtask

  task automatic convert_char(input logic [7:0] c, input logic last);
    int hi;
    int lo;
    if (!decoding) begin
      if (is_unreserved(c)) begin
        expect_char(c, last);
      end else if (c == CH_SPACE) begin
        expect_char(CH_PLUS, last);
      end else begin
        expect_char(CH_PCT, 1'b0);
        expect_char(upper_hex(c[7:4]), 1'b0);
        expect_char(upper_hex(c[3:0]), last);
      end
      esc_phase = ESC_NONE;
      held_char = 8'h00;
      return;
    end
    case (esc_phase)
      ESC_PCT_SEEN: begin
        if (last) begin
          // escape cut short by end of string: '%' goes out literally
          expect_char(CH_PCT, 1'b0);
          expect_char(plus_to_space(c), 1'b1);
          esc_phase = ESC_NONE;
          held_char = 8'h00;
        end else begin
          held_char = c;
          esc_phase = ESC_DIGIT_HELD;
        end
      end
      ESC_DIGIT_HELD: begin
        hi = nibble_of(held_char);
        lo = nibble_of(c);
        if (hi < 0)      expect_char(8'h00, last);
        else if (lo < 0) expect_char(8'(hi), last);
        else             expect_char(8'(hi * 16 + lo), last);
        esc_phase = ESC_NONE;
        held_char = 8'h00;
      end
      default: begin
        esc_phase = ESC_NONE;
        held_char = 8'h00;
        if (c == CH_PCT && !last) esc_phase = ESC_PCT_SEEN;
        else expect_char(plus_to_space(c), last);
      end
    endcase
  endtask

  always @(posedge clk) begin
    out_char_t want;
    if (rst) begin
      expected_chars.delete();
      decoding   = 1'b0;  // reset selects encoding
      esc_phase  = ESC_NONE;
      held_char  = 8'h00;
      fail_count = 0;
    end else begin
      // any direction write drops a pending escape
      if (cfg.valid && cfg.ready) begin
        decoding  = cfg.direction;
        esc_phase = ESC_NONE;
        held_char = 8'h00;
      end
      if (item.valid && item.ready) convert_char(item.in_byte, item.in_last);
      if (result.valid && result.ready) begin
        if (expected_chars.size() == 0) begin
          log_failure($sformatf("unexpected output byte %02h last %0b",
                                result.out_byte, result.out_last));
        end else begin
          want = expected_chars.pop_front();
          if (result.out_byte !== want.data || result.out_last !== want.last) begin
            log_failure($sformatf("output mismatch: expected %02h last %0b, got %02h last %0b",
                                  want.data, want.last, result.out_byte, result.out_last));
          end
        end
      end
    end
    pending <= expected_chars.size();
  end

endmodule

### verif/url_percent_codec_top_test.sv
// ----------------------------------------------------------------------------
// url_percent_codec_top_test
// Drives strings into the URL percent codec in both directions: a directed
// pass over the character classes and escape corner cases, then random
// strings with random gaps on both sides, a long output stall and a drain
// pause. A checker beside the block predicts and compares every output byte.
// ----------------------------------------------------------------------------
module url_percent_codec_top_test;
  timeunit 1ns;
  timeprecision 1ps;
  import upc_pkg::*;

  localparam logic DIR_ENCODE    = 1'b0;
  localparam logic DIR_DECODE    = 1'b1;
  localparam int   PHASES        = 8;
  localparam int   PHASE_CHARS   = 45;
  localparam int   SETTLE_CYCLES = 6;
  localparam int   LONG_HOLD     = 100;
  localparam int   STALL_LIMIT   = 2000;

  typedef logic [7:0] char_q_t [$];

  logic clk;
  logic rst;
  int   fail_count;
  int   pending;
  bit   gaps_on = 1'b1;
  bit   hold_request = 1'b0;

  upc_in_if  item ();
  upc_cfg_if cfg ();
  upc_out_if result ();

  url_percent_codec_top i_dut (
    .clk    (clk),
    .rst    (rst),
    .item   (item),
    .cfg    (cfg),
    .result (result)
  );

  url_percent_codec_checker i_checker (
    .clk        (clk),
    .rst        (rst),
    .item       (item),
    .cfg        (cfg),
    .result     (result),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic logic [7:0] rand_hex_char();
    logic [3:0] n;
    n = 4'($urandom_range(0, 15));
    if (n < 4'd10) return 8'h30 + 8'(n);
    return ($urandom_range(0, 1) != 0) ? 8'h57 + 8'(n) : 8'h37 + 8'(n);
  endfunction

  // mostly characters that stop a hex pair: whitespace, signs, letters past f
  function automatic logic [7:0] rand_non_hex();
    case ($urandom_range(0, 6))
      0:       return CH_SPACE;
      1:       return CH_PLUS;
      2:       return CH_DASH;
      3:       return 8'h67;
      4:       return 8'h47;
      5:       return 8'h09;
      default: return 8'($urandom);
    endcase
  endfunction

  task automatic build_string(input logic decoding, output char_q_t s);
    int len;
    len = $urandom_range(1, 12);
    s = {};
    while (s.size() < len) begin
      if (decoding) begin
        case ($urandom_range(0, 9))
          0, 1, 2, 3: begin
            s.push_back(CH_PCT);
            s.push_back(rand_hex_char());
            s.push_back(rand_hex_char());
          end
          4: begin
            s.push_back(CH_PCT);
            s.push_back(rand_hex_char());
            s.push_back(rand_non_hex());
          end
          5: begin
            s.push_back(CH_PCT);
            s.push_back(rand_non_hex());
            s.push_back(8'($urandom));
          end
          6:       s.push_back(CH_PCT);
          7:       s.push_back(CH_PLUS);
          default: s.push_back(8'($urandom));
        endcase
      end else begin
        case ($urandom_range(0, 5))
          0:       s.push_back(CH_SPACE);
          1:       s.push_back(CH_PCT);
          2:       s.push_back(8'h61 + 8'($urandom_range(0, 25)));
          default: s.push_back(8'($urandom));
        endcase
      end
    end
  endtask

  task automatic send_char(input logic [7:0] c, input logic last);
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      item.valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
    item.valid   <= 1'b1;
    item.in_byte <= c;
    item.in_last <= last;
    @(posedge clk);
    while (!item.ready) @(posedge clk);
  endtask

  task automatic send_string(input char_q_t s);
    foreach (s[k]) send_char(s[k], k == s.size() - 1);
  endtask

  // pending is registered in the checker, so it is sampled only once the checker has updated it
  task automatic wait_drained();
    item.valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_direction(input logic dir);
    wait_drained();
    cfg.valid     <= 1'b1;
    cfg.direction <= dir;
    @(posedge clk);
    while (!cfg.ready) @(posedge clk);
    cfg.valid <= 1'b0;
  endtask

  // output side: random bursts of backpressure, plus one long hold on request
  initial begin
    int hold_left;
    result.ready <= 1'b0;
    @(posedge clk);
    forever begin
      if (hold_request) begin
        hold_request = 1'b0;
        result.ready <= 1'b0;
        for (hold_left = LONG_HOLD; hold_left > 0; hold_left--) @(posedge clk);
      end else if (gaps_on && $urandom_range(0, 4) == 0) begin
        result.ready <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end else begin
        result.ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  initial begin
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if ((item.valid && item.ready) || (result.valid && result.ready) ||
          (cfg.valid && cfg.ready)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("CHECK FAILED");
    $finish;
  end

  initial begin
    char_q_t str;
    int      sent;
    int      strings;
    rst           <= 1'b1;
    item.valid    <= 1'b0;
    item.in_byte  <= 8'h00;
    item.in_last  <= 1'b0;
    cfg.valid     <= 1'b0;
    cfg.direction <= DIR_ENCODE;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // encode: unreserved set, space, and both byte extremes
    write_direction(DIR_ENCODE);
    str = {8'h7A, 8'h41, 8'h39, CH_DASH, CH_UNDER, CH_DOT, CH_TILDE, CH_SPACE,
           8'h00, 8'hFF};
    send_string(str);

    // decode: full pair, hex then non-hex, sign as first digit, sign as second
    write_direction(DIR_DECODE);
    str = {CH_PCT, 8'h34, 8'h31, CH_PCT, 8'h66, 8'h7A, CH_PCT, CH_DASH, 8'h31,
           CH_PCT, 8'h34, CH_PLUS};
    send_string(str);
    // truncated escapes at end of string
    str = {CH_PCT, CH_PCT};
    send_string(str);
    str = {CH_PCT, CH_PLUS};
    send_string(str);
    str = {CH_PCT};
    send_string(str);
    // direction write while an escape is pending drops it
    send_char(CH_PCT, 1'b0);
    send_char(8'h34, 1'b0);
    write_direction(DIR_DECODE);
    str = {8'h34, 8'h31};
    send_string(str);

    for (int p = 0; p < PHASES; p++) begin
      logic dir;
      dir = (p % 2 == 0) ? DIR_ENCODE : DIR_DECODE;
      if (p == PHASES - 1) gaps_on = 1'b0;
      write_direction(dir);
      if (p == 2) hold_request = 1'b1;
      sent    = 0;
      strings = 0;
      while (sent < PHASE_CHARS) begin
        build_string(dir == DIR_DECODE, str);
        send_string(str);
        sent += str.size();
        strings++;
        if (p == 3 && strings == 2) wait_drained();
      end
    end

    wait_drained();
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
